### rtl/core/fdc_pkg.sv
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared constants, command/status types and the name checksum step for the
// FAT directory compactor.
// ----------------------------------------------------------------------------
package fdc_pkg;

    // Directory entry byte codes
    localparam logic [7:0] BYTE_END       = 8'h00;
    localparam logic [7:0] BYTE_DELETED   = 8'hE5;
    localparam logic [7:0] ATTR_LFN       = 8'h0F;
    localparam logic [7:0] SEQ_START_BIT  = 8'h40;
    localparam logic [7:0] SEQ_MASK       = 8'hBF;

    // Entry geometry
    localparam int ENTRY_BITS = 256;
    localparam int NAME_LEN   = 11;
    localparam int PSUM_BYTES = 6;    // name bytes summed in the accept cycle

    // Result status codes
    localparam logic [1:0] STATUS_KEPT     = 2'd0;
    localparam logic [1:0] STATUS_BAD_SEQ  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;         // capture the input entry
        logic       drop_run;     // forget the buffered run
        logic       set_ended;    // halt the directory
        logic       set_in_run;   // a new run begins
        logic       store;        // append the entry to the run buffer
        logic       rd_first;     // read run entry 0
        logic       rd_next;      // read the following run entry
        logic       out_load;     // load the output register
        logic       out_from_run; // output data comes from the run buffer
        logic [1:0] out_status;
        logic       out_last;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic ended;
        logic b0_end;
        logic b0_deleted;
        logic is_lfn;
        logic seq_start;
        logic in_run;
        logic chk_match;
        logic seq_ok;
        logic run_full;
        logic sum_match;
        logic rd_last;
        logic out_free;
    } t_dp_sts;

    // One step of the rotate-right-and-add name checksum
    function automatic logic [7:0] sum_step(input logic [7:0] s, input logic [7:0] b);
        return {s[0], s[7:1]} + b;
    endfunction

endpackage

### rtl/core/fdc_if.sv
// ----------------------------------------------------------------------------
// fdc_entry_if / fdc_kept_if
// Valid/ready channels carrying directory entries in and kept entries out.
// ----------------------------------------------------------------------------
interface fdc_entry_if;
    logic        valid;
    logic        ready;
    logic        first_of_directory;
    logic [63:0] entry_word0;
    logic [63:0] entry_word1;
    logic [63:0] entry_word2;
    logic [63:0] entry_word3;

    modport source (output valid, first_of_directory, entry_word0, entry_word1,
                    entry_word2, entry_word3, input ready);
    modport sink   (input valid, first_of_directory, entry_word0, entry_word1,
                    entry_word2, entry_word3, output ready);
endinterface

interface fdc_kept_if;
    logic        valid;
    logic        ready;
    logic [63:0] kept_word0;
    logic [63:0] kept_word1;
    logic [63:0] kept_word2;
    logic [63:0] kept_word3;
    logic        run_end;
    logic [1:0]  status;

    modport source (output valid, kept_word0, kept_word1, kept_word2, kept_word3,
                    run_end, status, input ready);
    modport sink   (input valid, kept_word0, kept_word1, kept_word2, kept_word3,
                    run_end, status, output ready);
endinterface

### rtl/core/fdc_ctrl.sv
// ----------------------------------------------------------------------------
// fdc_ctrl
// Sequencer: classifies each captured entry and steers run buffering and
// result output in the datapath.
// ----------------------------------------------------------------------------
module fdc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  fdc_pkg::t_dp_sts i_sts,
    output fdc_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECIDE  = 3'd1;
    localparam logic [2:0] S_EMIT    = 3'd2;
    localparam logic [2:0] S_SHORT   = 3'd3;
    localparam logic [2:0] S_ERR_SEQ = 3'd4;
    localparam logic [2:0] S_ERR_OVF = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_IDLE;
                if (i_sts.ended || i_sts.b0_deleted) begin
                    n_state = S_IDLE;
                end else if (i_sts.b0_end) begin
                    o_cmd.drop_run  = 1'b1;
                    o_cmd.set_ended = 1'b1;
                end else if (i_sts.is_lfn) begin
                    if (i_sts.seq_start) begin
                        o_cmd.drop_run   = 1'b1;
                        o_cmd.set_in_run = 1'b1;
                        o_cmd.store      = 1'b1;
                    end else if (!i_sts.in_run || !i_sts.chk_match) begin
                        n_state = S_IDLE;
                    end else if (!i_sts.seq_ok) begin
                        o_cmd.drop_run  = 1'b1;
                        o_cmd.set_ended = 1'b1;
                        n_state         = S_ERR_SEQ;
                    end else if (i_sts.run_full) begin
                        o_cmd.drop_run = 1'b1;
                        n_state        = S_ERR_OVF;
                    end else begin
                        o_cmd.store = 1'b1;
                    end
                end else if (i_sts.in_run && i_sts.sum_match) begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    n_state = S_SHORT;
                end
            end
            S_EMIT: begin
                // one buffered long-name entry per free output slot
                if (i_sts.out_free) begin
                    o_cmd.out_load     = 1'b1;
                    o_cmd.out_from_run = 1'b1;
                    o_cmd.out_status   = fdc_pkg::STATUS_KEPT;
                    if (i_sts.rd_last) begin
                        n_state = S_SHORT;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                    end
                end
            end
            S_SHORT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = fdc_pkg::STATUS_KEPT;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.drop_run   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_ERR_SEQ: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = fdc_pkg::STATUS_BAD_SEQ;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_ERR_OVF: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = fdc_pkg::STATUS_OVERFLOW;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/core/fdc_datapath.sv
// ----------------------------------------------------------------------------
// fdc_datapath
// Entry register, name checksum, run state, run buffer memory and the output
// register of the FAT directory compactor.
// ----------------------------------------------------------------------------
module fdc_datapath #(
    parameter int RUN_DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fdc_pkg::t_dp_cmd i_cmd,
    output fdc_pkg::t_dp_sts o_sts,
    input  logic             i_first,
    input  logic [63:0]      i_word0,
    input  logic [63:0]      i_word1,
    input  logic [63:0]      i_word2,
    input  logic [63:0]      i_word3,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [63:0]      o_kept_word0,
    output logic [63:0]      o_kept_word1,
    output logic [63:0]      o_kept_word2,
    output logic [63:0]      o_kept_word3,
    output logic             o_run_end,
    output logic [1:0]       o_status
);

    localparam int CW = $clog2(RUN_DEPTH + 1);
    localparam int IW = $clog2(RUN_DEPTH);
    localparam int EB = fdc_pkg::ENTRY_BITS;

    // Captured entry and partial checksum
    logic [EB-1:0] r_entry;
    logic [7:0]    r_psum;
    logic [7:0]    w_psum;
    logic [7:0]    w_sum;

    // Run state
    logic          r_in_run;
    logic          r_ended;
    logic [7:0]    r_exp_seq;
    logic [7:0]    r_prev_chk;
    logic [CW-1:0] r_count;

    // Run buffer
    logic [EB-1:0] r_mem [RUN_DEPTH];
    logic [EB-1:0] r_rd_data;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] w_rd_addr;
    logic [IW-1:0] w_wr_addr;

    // Output register
    logic          r_out_valid;
    logic [EB-1:0] r_out_data;
    logic          r_out_last;
    logic [1:0]    r_out_status;

    logic [7:0]    w_b0;
    logic [7:0]    w_attr;
    logic [7:0]    w_chk;
    logic          w_out_free;

    assign w_b0   = r_entry[7:0];
    assign w_attr = r_entry[95:88];
    assign w_chk  = r_entry[111:104];

    // Name checksum, first bytes taken straight from the input
    always_comb begin
        w_psum = '0;
        for (int j = 0; j < fdc_pkg::PSUM_BYTES; j++) begin
            w_psum = fdc_pkg::sum_step(w_psum, i_word0[8*j +: 8]);
        end
    end

    // Remaining name bytes from the captured entry
    always_comb begin
        w_sum = r_psum;
        for (int j = fdc_pkg::PSUM_BYTES; j < fdc_pkg::NAME_LEN; j++) begin
            w_sum = fdc_pkg::sum_step(w_sum, r_entry[8*j +: 8]);
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // Status toward the controller
    always_comb begin
        o_sts            = '0;
        o_sts.ended      = r_ended;
        o_sts.b0_end     = (w_b0 == fdc_pkg::BYTE_END);
        o_sts.b0_deleted = (w_b0 == fdc_pkg::BYTE_DELETED);
        o_sts.is_lfn     = (w_attr == fdc_pkg::ATTR_LFN);
        o_sts.seq_start  = |(w_b0 & fdc_pkg::SEQ_START_BIT);
        o_sts.in_run     = r_in_run;
        o_sts.chk_match  = (w_chk == r_prev_chk);
        o_sts.seq_ok     = ({1'b0, r_exp_seq} == ({1'b0, w_b0} + 9'd1));
        o_sts.run_full   = (r_count >= CW'(RUN_DEPTH));
        o_sts.sum_match  = (w_sum == r_prev_chk);
        o_sts.rd_last    = ((CW'(r_idx) + CW'(1)) == r_count);
        o_sts.out_free   = w_out_free;
    end

    // Entry capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_entry <= {i_word3, i_word2, i_word1, i_word0};
            r_psum  <= w_psum;
        end
    end

    // Run and directory state; a first entry clears it as it is captured
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run   <= 1'b0;
            r_ended    <= 1'b0;
            r_exp_seq  <= '0;
            r_prev_chk <= '0;
            r_count    <= '0;
        end else if (i_cmd.load && i_first) begin
            r_in_run   <= 1'b0;
            r_ended    <= 1'b0;
            r_exp_seq  <= '0;
            r_prev_chk <= '0;
            r_count    <= '0;
        end else begin
            if (i_cmd.set_in_run) begin
                r_in_run <= 1'b1;
            end else if (i_cmd.drop_run) begin
                r_in_run <= 1'b0;
            end
            if (i_cmd.set_ended) begin
                r_ended <= 1'b1;
            end
            if (i_cmd.store) begin
                r_exp_seq  <= w_b0 & fdc_pkg::SEQ_MASK;
                r_prev_chk <= w_chk;
            end
            if (i_cmd.drop_run) begin
                r_count <= CW'(i_cmd.store);
            end else if (i_cmd.store) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // Run buffer write, entry 0 when a new run replaces the old one
    assign w_wr_addr = i_cmd.drop_run ? '0 : r_count[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[w_wr_addr] <= r_entry;
        end
    end

    // Run buffer read, registered
    assign w_rd_addr = i_cmd.rd_first ? '0 : (r_idx + IW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_first || i_cmd.rd_next) begin
            r_rd_data <= r_mem[w_rd_addr];
            r_idx     <= w_rd_addr;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data   <= i_cmd.out_from_run ? r_rd_data : r_entry;
            r_out_last   <= i_cmd.out_last;
            r_out_status <= i_cmd.out_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kept_word0 = r_out_data[63:0];
    assign o_kept_word1 = r_out_data[127:64];
    assign o_kept_word2 = r_out_data[191:128];
    assign o_kept_word3 = r_out_data[255:192];
    assign o_run_end    = r_out_last;
    assign o_status     = r_out_status;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(RUN_DEPTH))
        else $error("run count beyond buffer depth");

    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.store && !i_cmd.drop_run) |-> (r_count < CW'(RUN_DEPTH)))
        else $error("store into a full run buffer");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> w_out_free)
        else $error("output register overwritten before transfer");

    a_read_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_next |-> ((CW'(r_idx) + CW'(1)) < r_count))
        else $error("run read past buffered entries");

endmodule

### rtl/core/fat_directory_compactor_unit.sv
// ----------------------------------------------------------------------------
// fat_directory_compactor_unit
// Compacts a FAT directory stream: drops deleted entries, checks and keeps
// long-name runs whose checksum matches their short entry.
// ----------------------------------------------------------------------------
// Usage:
//   i_ent carries one 32-byte directory entry per transfer; set
//   first_of_directory on the first entry of each directory. o_kept carries
//   the kept entries, run_end marks the last result of one input entry and
//   status flags a bad long-name sequence or a run longer than RUN_DEPTH.
// Timing (receiver ready):
//   An entry with no result goes through capture, then classify, before the
//   next transfer; the name checksum is split between capture and classify.
//   An entry with one result adds an output step, and a short entry closing
//   a matching run of N long-name entries first emits the run, one buffered
//   entry per cycle from the run memory's registered read port.
// Reset:
//   Clears the sequencer, the run state and the output valid; the run
//   buffer contents are not cleared and need no clearing pass.
// Stall:
//   A single output register holds a result until it is taken; the next
//   input entry is accepted meanwhile, and the sequencer waits only when it
//   has another result to place.
// ----------------------------------------------------------------------------
module fat_directory_compactor_unit #(
    parameter int RUN_DEPTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fdc_entry_if.sink    i_ent,
    fdc_kept_if.source   o_kept
);

    fdc_pkg::t_dp_cmd w_cmd;
    fdc_pkg::t_dp_sts w_sts;

    fdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_ent.valid),
        .o_in_ready (i_ent.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    fdc_datapath #(
        .RUN_DEPTH (RUN_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_first      (i_ent.first_of_directory),
        .i_word0      (i_ent.entry_word0),
        .i_word1      (i_ent.entry_word1),
        .i_word2      (i_ent.entry_word2),
        .i_word3      (i_ent.entry_word3),
        .i_out_ready  (o_kept.ready),
        .o_out_valid  (o_kept.valid),
        .o_kept_word0 (o_kept.kept_word0),
        .o_kept_word1 (o_kept.kept_word1),
        .o_kept_word2 (o_kept.kept_word2),
        .o_kept_word3 (o_kept.kept_word3),
        .o_run_end    (o_kept.run_end),
        .o_status     (o_kept.status)
    );

endmodule

### tb/fdc_compaction_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fdc_compaction_checker
// Watches the entry and kept channels of the FAT directory compactor, keeps
// its own model of the run state, and compares every kept transfer with the
// oldest predicted result. Mismatch count and outstanding results go to the
// testbench top.
// ----------------------------------------------------------------------------
module fdc_compaction_checker #(
    parameter int RUN_DEPTH = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    fdc_entry_if  i_ent,
    fdc_kept_if   i_kept,
    output int    o_error_count,
    output int    o_pending
);

    typedef logic [3:0][63:0] t_dir_entry;

    typedef struct packed {
        t_dir_entry words;
        logic       run_end;
        logic [1:0] status;
    } t_kept_result;

    // Predicted kept transfers, oldest first
    t_kept_result expected_kept[$];

    // Model of the directory and long-name run state
    logic       in_run;
    logic       dir_ended;
    logic [7:0] expected_seq;
    logic [7:0] run_checksum;
    int         run_count;
    t_dir_entry run_buffer [RUN_DEPTH];
    int         results_seen;

    // Rotate-right-and-add over the 11 short-name bytes
    function automatic logic [7:0] name_sum(input t_dir_entry w);
        logic [7:0]  acc;
        logic [87:0] name;
        acc  = 8'h00;
        name = {w[1][23:0], w[0]};
        for (int j = 0; j < fdc_pkg::NAME_LEN; j++) begin
            acc = {acc[0], acc[7:1]} + name[8*j +: 8];
        end
        return acc;
    endfunction

    function automatic void queue_result(input t_dir_entry w, input logic last,
                                         input logic [1:0] st);
        t_kept_result r;
        r.words   = w;
        r.run_end = last;
        r.status  = st;
        expected_kept.insert(expected_kept.size(), r);
    endfunction

    // Work out the results one accepted entry causes
    task automatic predict_entry(input logic first, input t_dir_entry w);
        logic [7:0] b0;
        logic [7:0] attr;
        logic [7:0] lfn_chk;
        b0      = w[0][7:0];
        attr    = w[1][31:24];
        lfn_chk = w[1][47:40];

        if (first) begin
            in_run       = 1'b0;
            run_count    = 0;
            dir_ended    = 1'b0;
            expected_seq = 8'h00;
            run_checksum = 8'h00;
        end
        if (dir_ended) return;

        // End marker halts the directory and forgets any run
        if (b0 == fdc_pkg::BYTE_END) begin
            in_run    = 1'b0;
            run_count = 0;
            dir_ended = 1'b1;
            return;
        end
        if (b0 == fdc_pkg::BYTE_DELETED) return;

        // Long-name piece
        if (attr == fdc_pkg::ATTR_LFN) begin
            if ((b0 & fdc_pkg::SEQ_START_BIT) != 8'h00) begin
                in_run    = 1'b1;
                run_count = 0;
            end else begin
                if (!in_run) return;
                if (lfn_chk != run_checksum) return;
                if ({1'b0, expected_seq} != {1'b0, b0} + 9'd1) begin
                    in_run    = 1'b0;
                    run_count = 0;
                    dir_ended = 1'b1;
                    queue_result(w, 1'b1, fdc_pkg::STATUS_BAD_SEQ);
                    return;
                end
            end
            if (run_count >= RUN_DEPTH) begin
                in_run    = 1'b0;
                run_count = 0;
                queue_result(w, 1'b1, fdc_pkg::STATUS_OVERFLOW);
                return;
            end
            expected_seq          = b0 & fdc_pkg::SEQ_MASK;
            run_checksum          = lfn_chk;
            run_buffer[run_count] = w;
            run_count++;
            return;
        end

        // Short entry: the run goes out first when its checksum matches
        if (in_run && name_sum(w) == run_checksum) begin
            for (int k = 0; k < run_count; k++) begin
                queue_result(run_buffer[k], 1'b0, fdc_pkg::STATUS_KEPT);
            end
        end
        in_run    = 1'b0;
        run_count = 0;
        queue_result(w, 1'b1, fdc_pkg::STATUS_KEPT);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] kept result %0d, %s: got %h, expected %h",
                 $realtime, results_seen, what, got, want);
        o_error_count++;
    endtask

    task automatic check_result(input t_kept_result got);
        t_kept_result want;
        if (expected_kept.size() == 0) begin
            report_mismatch("transfer with no result pending", got.words[0], 64'h0);
            return;
        end
        want = expected_kept.pop_front();
        for (int i = 0; i < 4; i++) begin
            if (got.words[i] !== want.words[i]) begin
                report_mismatch($sformatf("kept_word%0d", i), got.words[i], want.words[i]);
            end
        end
        if (got.run_end !== want.run_end) begin
            report_mismatch("run_end", 64'(got.run_end), 64'(want.run_end));
        end
        if (got.status !== want.status) begin
            report_mismatch("status", 64'(got.status), 64'(want.status));
        end
    endtask

    // Sample both channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_run       = 1'b0;
            dir_ended    = 1'b0;
            expected_seq = 8'h00;
            run_checksum = 8'h00;
            run_count    = 0;
            results_seen = 0;
            o_error_count = 0;
            expected_kept.delete();
        end else begin
            if (i_ent.valid && i_ent.ready) begin
                predict_entry(i_ent.first_of_directory,
                              {i_ent.entry_word3, i_ent.entry_word2,
                               i_ent.entry_word1, i_ent.entry_word0});
            end
            if (i_kept.valid && i_kept.ready) begin
                check_result({i_kept.kept_word3, i_kept.kept_word2, i_kept.kept_word1,
                              i_kept.kept_word0, i_kept.run_end, i_kept.status});
                results_seen++;
            end
        end
        o_pending <= expected_kept.size();
    end

endmodule

### tb/fat_directory_compactor_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fat_directory_compactor_unit_test
// Drives directory entries into the compactor: a directed set covering
// deleted entries, end markers, orphan, restarted, broken and mismatched
// long-name runs, then random well-formed runs mixed with noise under
// varying sender and receiver idling. A checker beside the block predicts
// and compares every kept transfer.
// ----------------------------------------------------------------------------
module fat_directory_compactor_unit_test;

    localparam int RUN_DEPTH    = 32;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES  = 400;

    typedef logic [3:0][63:0] t_dir_entry;

    logic clk = 1'b0;
    logic rst_n;

    fdc_entry_if ent_bus ();
    fdc_kept_if  kept_bus ();

    int   error_count;
    int   pending_count;
    int   cycle_count = 0;
    int   items_sent;
    int   tx_idle_pct;
    int   rx_idle_pct;
    logic stall_rx;
    bit   dir_halted;

    fat_directory_compactor_unit #(
        .RUN_DEPTH (RUN_DEPTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_ent   (ent_bus),
        .o_kept  (kept_bus)
    );

    fdc_compaction_checker #(
        .RUN_DEPTH (RUN_DEPTH)
    ) kept_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_ent         (ent_bus),
        .i_kept        (kept_bus),
        .o_error_count (error_count),
        .o_pending     (pending_count)
    );

    always #1 clk = ~clk;

    // Receiver: random stalls plus a long hold when requested
    always @(posedge clk) begin
        kept_bus.ready <= !stall_rx && ($urandom_range(99) >= rx_idle_pct);
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_dir_entry rand_entry();
        t_dir_entry w;
        for (int i = 0; i < 4; i++) w[i] = rand64();
        return w;
    endfunction

    // Checksum a long-name run must carry to match this short entry
    function automatic logic [7:0] lfn_checksum_of(input t_dir_entry w);
        logic [7:0]  acc;
        logic [87:0] name;
        acc  = 8'h00;
        name = {w[1][23:0], w[0]};
        for (int j = 0; j < fdc_pkg::NAME_LEN; j++) begin
            acc = {acc[0], acc[7:1]} + name[8*j +: 8];
        end
        return acc;
    endfunction

    function automatic t_dir_entry short_entry();
        t_dir_entry w;
        w = rand_entry();
        while (w[0][7:0] == fdc_pkg::BYTE_END || w[0][7:0] == fdc_pkg::BYTE_DELETED)
            w[0][7:0] = 8'($urandom);
        while (w[1][31:24] == fdc_pkg::ATTR_LFN) w[1][31:24] = 8'($urandom);
        return w;
    endfunction

    function automatic t_dir_entry lfn_entry(input logic [7:0] seq, input logic [7:0] chk);
        t_dir_entry w;
        w = rand_entry();
        w[0][7:0]   = seq;
        w[1][31:24] = fdc_pkg::ATTR_LFN;
        w[1][47:40] = chk;
        return w;
    endfunction

    function automatic t_dir_entry marked_entry(input logic [7:0] b0);
        t_dir_entry w;
        w = rand_entry();
        w[0][7:0] = b0;
        return w;
    endfunction

    // One transfer; valid stays high afterward unless the next call idles
    task automatic send_entry(input logic first, input t_dir_entry w);
        while ($urandom_range(99) < tx_idle_pct) begin
            ent_bus.valid <= 1'b0;
            @(posedge clk);
        end
        ent_bus.valid              <= 1'b1;
        ent_bus.first_of_directory <= first;
        ent_bus.entry_word0        <= w[0];
        ent_bus.entry_word1        <= w[1];
        ent_bus.entry_word2        <= w[2];
        ent_bus.entry_word3        <= w[3];
        @(posedge clk);
        while (!ent_bus.ready) @(posedge clk);
        items_sent++;
    endtask

    // Sender goes quiet until every predicted result has been taken
    task automatic wait_for_drain();
        ent_bus.valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
    endtask

    // Well-formed run of n pieces and its short entry; mixed adds skipped pieces
    task automatic send_run(input logic first, input int n, input bit match, input bit mixed);
        t_dir_entry s;
        logic [7:0] c;
        logic [7:0] odd_seq;
        s = short_entry();
        c = lfn_checksum_of(s);
        if (!match) c = c ^ 8'($urandom_range(1, 255));
        for (int i = n; i >= 1; i--) begin
            send_entry((i == n) ? first : 1'b0,
                       lfn_entry((i == n) ? (8'(i) | fdc_pkg::SEQ_START_BIT) : 8'(i), c));
            if (mixed && $urandom_range(99) < 12) begin
                if ($urandom_range(1) == 0) begin
                    send_entry(1'b0, marked_entry(fdc_pkg::BYTE_DELETED));
                end else begin
                    odd_seq = 8'($urandom) & fdc_pkg::SEQ_MASK;
                    if (odd_seq == fdc_pkg::BYTE_END) odd_seq = 8'h01;
                    send_entry(1'b0, lfn_entry(odd_seq, c ^ 8'($urandom_range(1, 255))));
                end
            end
        end
        send_entry(1'b0, s);
    endtask

    task automatic random_scenario();
        int         pick;
        int         n;
        logic       first;
        logic [7:0] c;
        logic [7:0] bad_seq;
        t_dir_entry w;
        first      = dir_halted || ($urandom_range(99) < 15);
        dir_halted = 1'b0;
        pick       = $urandom_range(99);
        n          = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        c          = 8'($urandom);
        if (pick < 60) begin
            send_run(first, n, $urandom_range(9) != 0, 1'b1);
        end else if (pick < 70) begin
            // broken sequence: halts the directory with an error result
            do bad_seq = 8'($urandom) & fdc_pkg::SEQ_MASK;
            while (bad_seq == fdc_pkg::BYTE_END || bad_seq == 8'(n));
            send_entry(first, lfn_entry(8'(n + 1) | fdc_pkg::SEQ_START_BIT, c));
            send_entry(1'b0, lfn_entry(bad_seq, c));
            dir_halted = 1'b1;
        end else if (pick < 80) begin
            // end marker cuts a run short
            send_entry(first, lfn_entry(8'(n) | fdc_pkg::SEQ_START_BIT, c));
            send_entry(1'b0, marked_entry(fdc_pkg::BYTE_END));
            dir_halted = 1'b1;
        end else begin
            // noise
            w = rand_entry();
            case ($urandom_range(4))
                0: w[0][7:0] = fdc_pkg::BYTE_END;
                1: w[0][7:0] = fdc_pkg::BYTE_DELETED;
                default: ;
            endcase
            if ($urandom_range(2) == 0) w[1][31:24] = fdc_pkg::ATTR_LFN;
            send_entry(first, w);
            if (w[0][7:0] == fdc_pkg::BYTE_END) dir_halted = 1'b1;
        end
    endtask

    task automatic random_phase(input int tx_pct, input int rx_pct, input int n_items);
        int start;
        tx_idle_pct  = tx_pct;
        rx_idle_pct <= rx_pct;
        start        = items_sent;
        while (items_sent - start < n_items) random_scenario();
    endtask

    initial begin
        t_dir_entry s;
        t_dir_entry ones;
        logic [7:0] c;

        rst_n                      = 1'b0;
        ent_bus.valid              = 1'b0;
        ent_bus.first_of_directory = 1'b0;
        ent_bus.entry_word0        = '0;
        ent_bus.entry_word1        = '0;
        ent_bus.entry_word2        = '0;
        ent_bus.entry_word3        = '0;
        stall_rx                   = 1'b0;
        rx_idle_pct                = 0;
        tx_idle_pct                = 0;
        items_sent                 = 0;
        dir_halted                 = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct  = 21;
        rx_idle_pct <= 63;

        // Directed: plain short entry, deleted entry, matching and mismatched runs
        send_entry(1'b1, short_entry());
        send_entry(1'b0, marked_entry(fdc_pkg::BYTE_DELETED));
        send_run(1'b0, 2, 1'b1, 1'b0);
        send_run(1'b0, 1, 1'b0, 1'b0);
        // orphan long-name piece
        send_entry(1'b0, lfn_entry(8'h01, 8'($urandom)));

        // wrong-checksum piece and deleted entry inside a run are skipped
        s = short_entry();
        c = lfn_checksum_of(s);
        send_entry(1'b0, lfn_entry(8'h42, c));
        send_entry(1'b0, lfn_entry(8'h05, c ^ 8'h5A));
        send_entry(1'b0, marked_entry(fdc_pkg::BYTE_DELETED));
        send_entry(1'b0, lfn_entry(8'h01, c));
        send_entry(1'b0, s);

        // a run start inside a run drops the earlier pieces
        s = short_entry();
        c = lfn_checksum_of(s);
        send_entry(1'b0, lfn_entry(8'h43, c ^ 8'h33));
        send_entry(1'b0, lfn_entry(8'h41, c));
        send_entry(1'b0, s);

        // broken sequence halts until the next directory
        send_entry(1'b0, lfn_entry(8'h43, c));
        send_entry(1'b0, lfn_entry(8'h01, c));
        send_entry(1'b0, short_entry());
        send_entry(1'b1, short_entry());

        // end marker inside a run
        send_entry(1'b0, lfn_entry(8'h42, c));
        send_entry(1'b0, marked_entry(fdc_pkg::BYTE_END));
        send_entry(1'b0, short_entry());

        // all-ones and all-zero entries
        ones = '1;
        send_entry(1'b1, ones);
        send_entry(1'b1, '0);

        // highest sequence bytes
        s = short_entry();
        c = lfn_checksum_of(s);
        send_entry(1'b1, lfn_entry(8'hFF, c));
        send_entry(1'b0, lfn_entry(8'hBE, c));
        send_entry(1'b0, s);

        // Receiver holds off while the sender keeps offering runs
        fork
            begin
                stall_rx <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                stall_rx <= 1'b0;
            end
            begin
                repeat (6) send_run(1'b0, $urandom_range(1, 3), 1'b1, 1'b0);
            end
        join
        wait_for_drain();

        random_phase(21, 63, 6);
        wait_for_drain();
        random_phase(63, 21, 6);
        wait_for_drain();

        // No idling: full run, overflowing run, then random
        tx_idle_pct  = 0;
        rx_idle_pct <= 0;
        send_run(1'b1, RUN_DEPTH, 1'b1, 1'b0);
        send_run(1'b0, RUN_DEPTH + 1, 1'b1, 1'b0);
        dir_halted = 1'b0;
        random_phase(0, 0, 6);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
